FILE: rtl/core/lz4bd_pkg.sv
// Package for the LZ4 block decompressor: request and result payload types,
// error codes. No dependencies.
`default_nettype none
package lz4bd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
    logic       last_in;
  } lz4bd_req_t;

  typedef struct packed {
    logic [7:0] out_data;
    logic       out_last;
    logic [2:0] out_error;
  } lz4bd_res_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_ZERO_OFF = 3'd1;
  localparam logic [2:0] ERR_FAR_OFF  = 3'd2;
  localparam logic [2:0] ERR_BUSY     = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_PULL = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/lz4bd_hist_mem.sv
// History memory for the LZ4 block decompressor: one write port, one read
// port, registered read data. Depends on nothing.
`default_nettype none
module lz4bd_hist_mem #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);
  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/lz4_block_decompressor_top.sv
// Top level of the LZ4 block decompressor: parser, history memory control
// and output register. Depends on lz4bd_pkg and lz4bd_hist_mem.
//
//  channel | direction | payload           | handshake
//  in_     | input     | lz4bd_req_t       | in_valid / in_ready
//  out_    | output    | lz4bd_res_t       | out_valid / out_ready
//
// One request per cycle, compressed byte or pull; a result appears in the
// output register the cycle after its request is accepted. A pull reads the
// history memory in the accept cycle; the byte arrives the next cycle in the
// result stage, where it is written back. A following pull reading that same
// entry (distance 1) takes the byte forwarded from the result stage. A result
// waits in the output register while the next request is taken, as long as
// that register frees up this cycle; in_ready drops only while a result is
// held and out_ready is low. Reset clears control state only; the history
// memory needs no clearing pass.
`default_nettype none
module lz4_block_decompressor_top #(
  parameter int WINDOW_BYTES = 65536,
  parameter int LENGTH_BITS  = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lz4bd_pkg::lz4bd_req_t in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lz4bd_pkg::lz4bd_res_t      out_data
);
  import lz4bd_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam logic [LB:0] LEN_MAX = {1'b0, {LB{1'b1}}};
  localparam logic [16:0] WIN = 17'(WINDOW_BYTES);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MATEXT, PH_COPY
  } phase_t;

  phase_t          phase_r;
  logic [15:0]     wpos_r;
  logic [16:0]     prod_r;
  logic [LB-1:0]   lit_r;
  logic [LB-1:0]   macc_r;
  logic [15:0]     dist_r;
  logic [LB-1:0]   copies_r;
  logic            skip_r;
  logic [3:0]      nib_r;

  // result stage
  logic            ov_r;
  lz4bd_res_t      ores_r;
  logic            pend_r;     // a pull byte arrives from the memory this cycle
  logic            fwd_r;      // take the pull byte from lastb_r instead
  logic [15:0]     pwaddr_r;   // write address for pending pull byte
  logic [7:0]      lastb_r;    // last pull byte written to history

  logic [7:0]      rd_q;
  logic [7:0]      pull_byte;
  assign pull_byte = fwd_r ? lastb_r : rd_q;

  assign in_ready  = !ov_r || out_ready;
  assign out_valid = ov_r;
  always_comb begin
    out_data = ores_r;
    if (pend_r) out_data.out_data = pull_byte;
  end

  wire acc = in_valid && in_ready;

  // next state
  phase_t          phase_nxt;
  logic [15:0]     wpos_nxt;
  logic [16:0]     prod_nxt;
  logic [LB-1:0]   lit_nxt, macc_nxt, copies_nxt;
  logic [15:0]     dist_nxt;
  logic            skip_nxt;
  logic [3:0]      nib_nxt;
  logic            emit, is_pull, wr_lit;
  lz4bd_res_t      res;
  logic [LB:0]     sum;
  logic [LB+1:0]   sum4;
  logic [15:0]     d16;
  logic            put;
  logic            fail;
  logic [2:0]      code;
  logic            endb;

  always_comb begin
    phase_nxt = phase_r; wpos_nxt = wpos_r; prod_nxt = prod_r;
    lit_nxt = lit_r; macc_nxt = macc_r; copies_nxt = copies_r;
    dist_nxt = dist_r; skip_nxt = skip_r; nib_nxt = nib_r;
    emit = 1'b0; is_pull = 1'b0; wr_lit = 1'b0; put = 1'b0;
    fail = 1'b0; code = ERR_NONE; endb = 1'b0;
    res = '0;
    sum = {1'b0, lit_r} + (LB+1)'(in_data.in_byte);
    sum4 = '0;
    d16 = {in_data.in_byte, dist_r[7:0]};
    if (in_data.kind == KIND_PULL) begin
      if (!skip_r && phase_r == PH_COPY && copies_r != '0) begin
        is_pull = 1'b1; emit = 1'b1; put = 1'b1;
        copies_nxt = copies_r - LB'(1);
        if (copies_r == LB'(1)) phase_nxt = PH_TOKEN;
      end
    end else if (skip_r) begin
      if (in_data.last_in) endb = 1'b1;
    end else begin
      unique case (phase_r)
        PH_TOKEN: begin
          nib_nxt = in_data.in_byte[3:0];
          lit_nxt = LB'(in_data.in_byte[7:4]);
          if (in_data.in_byte[7:4] != 4'h0) begin
            if (in_data.last_in) begin fail = 1'b1; code = ERR_TRUNC; end
            else phase_nxt = (in_data.in_byte[7:4] == 4'hF) ? PH_LITEXT : PH_LIT;
          end else if (in_data.last_in) begin
            if (prod_r == '0) endb = 1'b1;
            else begin fail = 1'b1; code = ERR_TRUNC; end
          end else phase_nxt = PH_OFFLO;
        end
        PH_LITEXT: begin
          if (sum > LEN_MAX) begin fail = 1'b1; code = ERR_OVERFLOW; end
          else if (in_data.last_in) begin fail = 1'b1; code = ERR_TRUNC; end
          else begin
            lit_nxt = sum[LB-1:0];
            if (in_data.in_byte != 8'hFF) phase_nxt = PH_LIT;
          end
        end
        PH_LIT: begin
          if (in_data.last_in && lit_r != LB'(1)) begin
            fail = 1'b1; code = ERR_TRUNC;
          end else begin
            put = 1'b1; wr_lit = 1'b1; emit = 1'b1;
            res.out_data = in_data.in_byte;
            lit_nxt = lit_r - LB'(1);
            if (lit_r == LB'(1)) begin
              if (in_data.last_in) begin endb = 1'b1; res.out_last = 1'b1; end
              else phase_nxt = PH_OFFLO;
            end
          end
        end
        PH_OFFLO: begin
          if (in_data.last_in) begin fail = 1'b1; code = ERR_TRUNC; end
          else begin
            dist_nxt = {8'h00, in_data.in_byte};
            phase_nxt = PH_OFFHI;
          end
        end
        PH_OFFHI: begin
          dist_nxt = d16;
          if (d16 == '0) begin fail = 1'b1; code = ERR_ZERO_OFF; end
          else if ({1'b0, d16} > prod_r) begin fail = 1'b1; code = ERR_FAR_OFF; end
          else if (in_data.last_in) begin fail = 1'b1; code = ERR_TRUNC; end
          else if (nib_r == 4'hF) begin
            macc_nxt = LB'(15); phase_nxt = PH_MATEXT;
          end else begin
            copies_nxt = LB'(nib_r) + LB'(4); phase_nxt = PH_COPY;
          end
        end
        PH_MATEXT: begin
          sum = {1'b0, macc_r} + (LB+1)'(in_data.in_byte);
          sum4 = {1'b0, sum} + (LB+2)'(4);
          if (sum > LEN_MAX ||
              (in_data.in_byte != 8'hFF && sum4 > {1'b0, LEN_MAX})) begin
            fail = 1'b1; code = ERR_OVERFLOW;
          end else if (in_data.last_in) begin fail = 1'b1; code = ERR_TRUNC; end
          else begin
            macc_nxt = sum[LB-1:0];
            if (in_data.in_byte != 8'hFF) begin
              copies_nxt = sum4[LB-1:0]; phase_nxt = PH_COPY;
            end
          end
        end
        default: begin fail = 1'b1; code = ERR_BUSY; end
      endcase
    end
    if (put) begin
      wpos_nxt = wpos_r + 16'd1;
      if (prod_r < WIN) prod_nxt = prod_r + 17'd1;
    end
    if (fail) begin
      emit = 1'b1; res = '0; res.out_last = 1'b1; res.out_error = code;
      endb = 1'b1;
    end
    if (endb) begin
      phase_nxt = PH_TOKEN; prod_nxt = '0; lit_nxt = '0; macc_nxt = '0;
      dist_nxt = '0; copies_nxt = '0; nib_nxt = '0;
      skip_nxt = fail && !in_data.last_in;
    end
  end

  // history memory: a literal goes in at accept, a pull byte the cycle after
  // its read. A literal never directly follows a pull (a token always comes
  // between them), so the two writes never meet in one cycle.
  wire [15:0] rd_addr = wpos_r - dist_r;

  logic        mem_we;
  logic [15:0] mem_wa;
  logic [7:0]  mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_wa = wpos_r; mem_wd = in_data.in_byte;
    if (pend_r) begin
      mem_we = 1'b1; mem_wa = pwaddr_r; mem_wd = pull_byte;
    end else if (acc && wr_lit) begin
      mem_we = 1'b1;
    end
  end

  lz4bd_hist_mem #(.AW(16)) u_hist (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (acc && is_pull),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  // forwarding: a pull that reads the entry written this cycle takes the
  // byte from lastb_r on the next cycle
  logic fwd_nxt;
  assign fwd_nxt = pend_r && (rd_addr == pwaddr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOKEN; wpos_r <= '0; prod_r <= '0; lit_r <= '0;
      macc_r <= '0; dist_r <= '0; copies_r <= '0; skip_r <= 1'b0;
      nib_r <= '0; ov_r <= 1'b0; pend_r <= 1'b0; fwd_r <= 1'b0;
    end else begin
      pend_r <= acc && is_pull;
      if (pend_r) lastb_r <= pull_byte;
      if (acc) begin
        phase_r <= phase_nxt; wpos_r <= wpos_nxt; prod_r <= prod_nxt;
        lit_r <= lit_nxt; macc_r <= macc_nxt; copies_r <= copies_nxt;
        dist_r <= dist_nxt; skip_r <= skip_nxt; nib_r <= nib_nxt;
        fwd_r <= fwd_nxt;
        pwaddr_r <= wpos_r;
        ov_r <= emit; ores_r <= res;
      end else begin
        // hold the result, capturing a pull byte as it arrives
        if (out_ready) ov_r <= 1'b0;
        ores_r <= out_data;
      end
    end
  end
endmodule
`default_nettype wire
